[sv/drq_pkg.sv]
// ----------------------------------------------------------------------------
// drq_pkg
// Shared types, sizes and codes for the deferred release queue.
// ----------------------------------------------------------------------------
package drq_pkg;

  // ring size and derived widths
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;

  // command codes
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_PROCESS  = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

  // one stored ring entry
  typedef struct packed {
    logic [DATA_W-1:0] user;
    logic [DATA_W-1:0] due;
  } entry_t;

  // classified command handed from front to back
  // frame holds the due frame for a schedule, the current frame for a process
  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] user;
    logic [DATA_W-1:0] frame;
  } cmd_t;

  // one result item
  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] user;
    logic              last;
  } res_t;

  // ring slot of base plus offset, offset below the depth
  function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[sv/drq_ram.sv]
// ----------------------------------------------------------------------------
// drq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module drq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/drq_front.sv]
// ----------------------------------------------------------------------------
// drq_front
// Input side: takes items, forms the due frame and queues commands.
// ----------------------------------------------------------------------------
module drq_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_command,
  input  logic [drq_pkg::DATA_W-1:0] in_user_id,
  input  logic [drq_pkg::DATA_W-1:0] in_delay_frames,
  input  logic [drq_pkg::DATA_W-1:0] in_current_frame,
  output logic                       cmd_valid,
  output drq_pkg::cmd_t              cmd,
  input  logic                       cmd_pop
);

  drq_pkg::cmd_t ent_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  drq_pkg::cmd_t new_cmd;
  logic          do_push;
  logic          do_pop;

  // classify the item: schedules carry their due frame
  always_comb begin
    new_cmd.command = in_command;
    new_cmd.user    = in_user_id;
    if (in_command == drq_pkg::CMD_SCHEDULE) begin
      new_cmd.frame = in_current_frame + in_delay_frames;
    end else begin
      new_cmd.frame = in_current_frame;
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = ent_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // pointer and occupancy update
  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // command storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= new_cmd;
    end
  end

endmodule

[sv/drq_back.sv]
// ----------------------------------------------------------------------------
// drq_back
// Execution side: searches, updates and pops the ring of pending releases.
// ----------------------------------------------------------------------------
module drq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  drq_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          res_valid,
  output drq_pkg::res_t res,
  input  logic          res_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_PREAD,
    S_PCHK,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [drq_pkg::IDX_W-1:0]     head_r, head_nxt;
  logic [drq_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [drq_pkg::CNT_W-1:0]     off_r, off_nxt;
  logic                          pend_r, pend_nxt;
  logic [drq_pkg::IDX_W-1:0]     pslot_r, pslot_nxt;
  logic [drq_pkg::DATA_W-1:0]    user_r, user_nxt;
  logic [drq_pkg::DATA_W-1:0]    frame_r, frame_nxt;
  drq_pkg::status_t              status_r, status_nxt;
  logic [drq_pkg::DATA_W-1:0]    rel_user_r, rel_user_nxt;
  logic                          have_rel_r, have_rel_nxt;

  logic                          ram_we;
  logic [drq_pkg::IDX_W-1:0]     ram_waddr;
  drq_pkg::entry_t               ram_wdata;
  logic                          ram_re;
  logic [drq_pkg::IDX_W-1:0]     ram_raddr;
  logic [$bits(drq_pkg::entry_t)-1:0] ram_rdata;
  drq_pkg::entry_t               rd_ent;
  logic                          hit;
  logic                          is_due;
  logic                          rel_fire;

  assign rd_ent = drq_pkg::entry_t'(ram_rdata);
  assign hit    = pend_r && (rd_ent.user == user_r);
  assign is_due = (rd_ent.due <= frame_r);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    off_nxt      = off_r;
    pend_nxt     = 1'b0;
    pslot_nxt    = pslot_r;
    user_nxt     = user_r;
    frame_nxt    = frame_r;
    status_nxt   = status_r;
    rel_user_nxt = rel_user_r;
    have_rel_nxt = have_rel_r;
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pslot_r;
    ram_wdata    = '{user: user_r, due: frame_r};
    ram_re       = 1'b0;
    ram_raddr    = head_r;
    res_valid    = 1'b0;
    res          = '{status: status_r, user: rel_user_r, last: 1'b1};
    rel_fire     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop      = 1'b1;
          user_nxt     = cmd.user;
          frame_nxt    = cmd.frame;
          off_nxt      = '0;
          have_rel_nxt = 1'b0;
          rel_user_nxt = '0;
          state_nxt    = (cmd.command == drq_pkg::CMD_SCHEDULE) ? S_SEARCH : S_PREAD;
        end
      end
      // pipelined search: one read issued and one compare per cycle
      S_SEARCH: begin
        ram_raddr = drq_pkg::slot_add(head_r, off_r);
        priority if (hit) begin
          ram_we     = 1'b1;
          ram_waddr  = pslot_r;
          status_nxt = drq_pkg::ST_UPDATED;
          state_nxt  = S_DONE;
        end else if (!pend_r && (off_r == cnt_r)) begin
          if (cnt_r == drq_pkg::CNT_W'(drq_pkg::QUEUE_DEPTH)) begin
            status_nxt = drq_pkg::ST_FULL;
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = drq_pkg::slot_add(head_r, cnt_r);
            cnt_nxt    = cnt_r + 1'b1;
            status_nxt = drq_pkg::ST_ADDED;
          end
          state_nxt = S_DONE;
        end else begin
          if (off_r != cnt_r) begin
            ram_re    = 1'b1;
            pend_nxt  = 1'b1;
            pslot_nxt = ram_raddr;
            off_nxt   = off_r + 1'b1;
          end
        end
      end
      // read the head entry, or close out when the ring is empty
      S_PREAD: begin
        if (cnt_r == '0) begin
          status_nxt = have_rel_r ? drq_pkg::ST_RELEASED : drq_pkg::ST_NONE;
          state_nxt  = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = head_r;
          state_nxt = S_PCHK;
        end
      end
      // hold one released user back until the next head decides last
      S_PCHK: begin
        res = '{status: drq_pkg::ST_RELEASED, user: rel_user_r, last: 1'b0};
        if (is_due) begin
          if (!have_rel_r || res_ready) begin
            res_valid    = have_rel_r;
            rel_fire     = 1'b1;
            rel_user_nxt = rd_ent.user;
            have_rel_nxt = 1'b1;
            head_nxt     = drq_pkg::slot_add(head_r, drq_pkg::CNT_W'(1));
            cnt_nxt      = cnt_r - 1'b1;
            state_nxt    = S_PREAD;
          end
        end else begin
          status_nxt = have_rel_r ? drq_pkg::ST_RELEASED : drq_pkg::ST_NONE;
          state_nxt  = S_DONE;
        end
      end
      // final result of the item
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      cnt_r      <= '0;
      pend_r     <= 1'b0;
      have_rel_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
      have_rel_r <= have_rel_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    pslot_r    <= pslot_nxt;
    user_r     <= user_nxt;
    frame_r    <= frame_nxt;
    status_r   <= status_nxt;
    rel_user_r <= rel_user_nxt;
  end

  // ring of user and due frame pairs
  drq_ram #(
    .WIDTH ($bits(drq_pkg::entry_t)),
    .DEPTH (drq_pkg::QUEUE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

`ifndef SYNTHESIS
  // occupancy never passes the ring size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= drq_pkg::CNT_W'(drq_pkg::QUEUE_DEPTH))
    else $error("ring occupancy above depth");

  // each release removes exactly one entry
  a_rel_dec: assert property (@(posedge clk) disable iff (!rst_n)
    rel_fire |=> cnt_r == drq_pkg::CNT_W'($past(cnt_r) - 1'b1))
    else $error("release did not pop one entry");

  // the ring is only written while a schedule resolves
  a_we_sched: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_SEARCH)
    else $error("ring write outside schedule");

  // a release in flight only ever comes from a due head entry
  a_rel_due: assert property (@(posedge clk) disable iff (!rst_n)
    rel_fire |-> (state_r == S_PCHK) && is_due && (cnt_r != '0))
    else $error("release of an entry not due");
`endif

endmodule

[sv/drq_resq.sv]
// ----------------------------------------------------------------------------
// drq_resq
// Two-entry result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
module drq_resq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       res_valid,
  input  drq_pkg::res_t              res,
  output logic                       res_ready,
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 out_status,
  output logic [drq_pkg::DATA_W-1:0] out_released_user,
  output logic                       out_last
);

  drq_pkg::res_t ent_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign res_ready         = (cnt_r != 2'd2);
  assign empty             = (cnt_r == 2'd0);
  assign do_push           = res_valid && res_ready;
  assign do_pop            = pop && !empty;
  assign out_status        = ent_r[rp_r].status;
  assign out_released_user = ent_r[rp_r].user;
  assign out_last          = ent_r[rp_r].last;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= do_push ? !wp_r : wp_r;
      rp_r  <= do_pop ? !rp_r : rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= res;
    end
  end

endmodule

[sv/deferred_release_queue.sv]
// ----------------------------------------------------------------------------
// deferred_release_queue
// Ring of pending resource releases keyed by user, with schedule and process.
// ----------------------------------------------------------------------------
//  channel  handshake       payload
//  input    push / full     in_command, in_user_id, in_delay_frames,
//                           in_current_frame
//  result   empty / pop     out_status, out_released_user, out_last
//
//  A schedule holds the back end while the search reads one ring entry per
//  cycle, up to every live entry, through the single ring read port. A
//  process holds it while each due head entry is read and released, then
//  closes out on an empty ring or on a head not yet due. Each command
//  passes through the registered command queue after the input transfer.
//  Synchronous active-low reset empties the ring; no clearing pass is needed.
//  Two commands queue ahead of the back end; two results queue behind it, and
//  a stalled result side halts the back end only when that queue is full.
// ----------------------------------------------------------------------------
module deferred_release_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_command,
  input  logic [drq_pkg::DATA_W-1:0] in_user_id,
  input  logic [drq_pkg::DATA_W-1:0] in_delay_frames,
  input  logic [drq_pkg::DATA_W-1:0] in_current_frame,
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 out_status,
  output logic [drq_pkg::DATA_W-1:0] out_released_user,
  output logic                       out_last
);

  logic          cmd_valid;
  drq_pkg::cmd_t cmd;
  logic          cmd_pop;
  logic          res_valid;
  drq_pkg::res_t res;
  logic          res_ready;

  // accept and classify
  drq_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_command       (in_command),
    .in_user_id       (in_user_id),
    .in_delay_frames  (in_delay_frames),
    .in_current_frame (in_current_frame),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  // execute against the ring
  drq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // result transfer side
  drq_resq u_resq (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res               (res),
    .res_ready         (res_ready),
    .empty             (empty),
    .pop               (pop),
    .out_status        (out_status),
    .out_released_user (out_released_user),
    .out_last          (out_last)
  );

endmodule
